>>> design/sepq_pkg.sv
// ============================================================================
// sepq_pkg: shared types and constants for the sorted event priority queue
// Entry layout, result word, memory request bundle, sequencer states and
// circular address helpers.
// ============================================================================
`default_nettype none

package sepq_pkg;

    localparam int DEPTH       = 64;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int KEY_W       = 24;
    localparam int TRAVEL_W    = 20;
    localparam int SHIPS_W     = 16;
    localparam int ATK_W       = 4;
    localparam int PLANET_W    = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [TRAVEL_W-1:0] travel;
        logic [SHIPS_W-1:0]  ships;
        logic [ATK_W-1:0]    attacker;
        logic [PLANET_W-1:0] source;
        logic [PLANET_W-1:0] target;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t                status;
        entry_t                 popped;
        logic [COUNT_OUT_W-1:0] count_after;
        logic                   head_valid;
        logic [KEY_W-1:0]       head_key;
    } result_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PLACE,
        S_POP_HEAD,
        S_POP_NEXT,
        S_FINISH
    } state_t;

    function automatic addr_t addr_inc(addr_t a);
        return (a == addr_t'(DEPTH - 1)) ? '0 : a + addr_t'(1);
    endfunction

    function automatic addr_t addr_dec(addr_t a);
        return (a == '0) ? addr_t'(DEPTH - 1) : a - addr_t'(1);
    endfunction

    // Address of the last stored entry; cnt is at least one.
    function automatic addr_t addr_tail(addr_t head, count_t cnt);
        count_t          cm1;
        logic [ADDR_W:0] sum;
        cm1 = cnt - count_t'(1);
        sum = {1'b0, head} + {1'b0, cm1[ADDR_W-1:0]};
        if (sum >= (ADDR_W + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/sepq_if.sv
// ============================================================================
// sepq_if: request and response channels of the event queue
// Valid/ready channels; a word moves at a clock edge with both high.
// ============================================================================
`default_nettype none

interface sepq_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [sepq_pkg::KEY_W-1:0]     arrival_key;
    logic [sepq_pkg::TRAVEL_W-1:0]  travel_time;
    logic [sepq_pkg::SHIPS_W-1:0]   ship_count;
    logic [sepq_pkg::ATK_W-1:0]     attacker_index;
    logic [sepq_pkg::PLANET_W-1:0]  source_index;
    logic [sepq_pkg::PLANET_W-1:0]  target_index;

    modport source (
        output valid, operation, arrival_key, travel_time, ship_count,
               attacker_index, source_index, target_index,
        input  ready
    );

    modport sink (
        input  valid, operation, arrival_key, travel_time, ship_count,
               attacker_index, source_index, target_index,
        output ready
    );
endinterface

interface sepq_out_if;
    logic                              valid;
    logic                              ready;
    logic [sepq_pkg::STATUS_W-1:0]     status;
    logic [sepq_pkg::KEY_W-1:0]        popped_key;
    logic [sepq_pkg::TRAVEL_W-1:0]     popped_travel;
    logic [sepq_pkg::SHIPS_W-1:0]      popped_ships;
    logic [sepq_pkg::ATK_W-1:0]        popped_attacker;
    logic [sepq_pkg::PLANET_W-1:0]     popped_source;
    logic [sepq_pkg::PLANET_W-1:0]     popped_target;
    logic [sepq_pkg::COUNT_OUT_W-1:0]  count_after;
    logic                              head_valid;
    logic [sepq_pkg::KEY_W-1:0]        head_key;

    modport source (
        output valid, status, popped_key, popped_travel, popped_ships,
               popped_attacker, popped_source, popped_target, count_after,
               head_valid, head_key,
        input  ready
    );

    modport sink (
        input  valid, status, popped_key, popped_travel, popped_ships,
               popped_attacker, popped_source, popped_target, count_after,
               head_valid, head_key,
        output ready
    );
endinterface

`default_nettype wire

>>> design/sepq_ram.sv
// ============================================================================
// sepq_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module sepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/sepq_seq.sv
// ============================================================================
// sepq_seq: queue sequencer
// Keeps the entries as a sorted ring in the RAM. Insert walks back from the
// tail, moving larger keys up one slot; pop reads the head and advances it.
// ============================================================================
`default_nettype none

module sepq_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sepq_in_if.sink                 request,
    output      sepq_pkg::mem_req_t mem_req,
    input  wire sepq_pkg::entry_t   mem_rdata,
    output      logic               res_valid,
    output      sepq_pkg::result_t  res,
    input  wire logic               out_free
);

    import sepq_pkg::*;

    state_t  state_reg,     state_next;
    addr_t   head_reg,      head_next;
    count_t  count_reg,     count_next;
    logic [KEY_W-1:0] head_key_reg, head_key_next;
    addr_t   scan_addr_reg, scan_addr_next;
    count_t  scan_left_reg, scan_left_next;
    entry_t  new_entry_reg, new_entry_next;
    status_t status_reg,    status_next;
    entry_t  popped_reg,    popped_next;
    entry_t  in_entry;

    assign in_entry.key      = request.arrival_key;
    assign in_entry.travel   = request.travel_time;
    assign in_entry.ships    = request.ship_count;
    assign in_entry.attacker = request.attacker_index;
    assign in_entry.source   = request.source_index;
    assign in_entry.target   = request.target_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            head_key_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            head_key_reg <= head_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        new_entry_reg <= new_entry_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        head_key_next  = head_key_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        new_entry_next = new_entry_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = scan_addr_reg;
        mem_req.wdata = new_entry_reg;
        mem_req.re    = 1'b0;
        mem_req.raddr = scan_addr_reg;

        request.ready = (state_reg == S_IDLE);
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    popped_next    = '0;
                    status_next    = ST_DONE;
                    new_entry_next = in_entry;
                    if (request.operation == OP_INSERT)
                    begin
                        if (count_reg == count_t'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = head_reg;
                            mem_req.wdata = in_entry;
                            count_next    = count_reg + count_t'(1);
                            head_key_next = in_entry.key;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            // start at the tail and walk toward the head
                            mem_req.re     = 1'b1;
                            mem_req.raddr  = addr_tail(head_reg, count_reg);
                            scan_addr_next = addr_tail(head_reg, count_reg);
                            scan_left_next = count_reg;
                            state_next     = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = head_reg;
                            state_next    = S_POP_HEAD;
                        end
                    end
                end
            end

            S_INS_SCAN:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_inc(scan_addr_reg);
                if (mem_rdata.key > new_entry_reg.key)
                begin
                    // move the larger entry up one slot
                    mem_req.wdata = mem_rdata;
                    if (scan_left_reg == count_t'(1))
                    begin
                        head_key_next = new_entry_reg.key;
                        state_next    = S_INS_PLACE;
                    end
                    else
                    begin
                        mem_req.re     = 1'b1;
                        mem_req.raddr  = addr_dec(scan_addr_reg);
                        scan_addr_next = addr_dec(scan_addr_reg);
                        scan_left_next = scan_left_reg - count_t'(1);
                    end
                end
                else
                begin
                    mem_req.wdata = new_entry_reg;
                    count_next    = count_reg + count_t'(1);
                    state_next    = S_FINISH;
                end
            end

            S_INS_PLACE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = scan_addr_reg;
                mem_req.wdata = new_entry_reg;
                count_next    = count_reg + count_t'(1);
                state_next    = S_FINISH;
            end

            S_POP_HEAD:
            begin
                popped_next = mem_rdata;
                head_next   = addr_inc(head_reg);
                count_next  = count_reg - count_t'(1);
                if (count_reg == count_t'(1))
                begin
                    head_key_next = '0;
                    state_next    = S_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = addr_inc(head_reg);
                    state_next    = S_POP_NEXT;
                end
            end

            S_POP_NEXT:
            begin
                head_key_next = mem_rdata.key;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.popped      = popped_reg;
    assign res.count_after = COUNT_OUT_W'(count_reg);
    assign res.head_valid  = (count_reg != '0);
    assign res.head_key    = head_key_reg;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("RAM read and write hit the same slot");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_HEAD) |-> (count_reg != '0))
        else $error("pop reached head read on an empty queue");

    a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_SCAN) |->
            ((count_reg < count_t'(DEPTH)) && (scan_left_reg != '0)
             && (scan_left_reg <= count_reg)))
        else $error("insert scan without room or past the head");

    a_head_moves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_POP_HEAD) |=> (head_reg == $past(head_reg)))
        else $error("head moved outside a pop");

    a_empty_head_key: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_key_reg == '0))
        else $error("head key not cleared on empty queue");
`endif

endmodule

`default_nettype wire

>>> design/sorted_event_priority_queue.sv
// ============================================================================
// sorted_event_priority_queue: time-ordered event queue
// Sorted ring of up to DEPTH entries in one RAM; insert keeps equal keys in
// arrival order, pop returns the head. One response word per request word.
// ============================================================================
//
//   channel    dir  modport            word
//   request    in   sepq_in_if.sink    operation + new entry fields
//   response   out  sepq_out_if.source status, popped entry, count, head key
//
// Pop reads the head, then the next head unless one entry was stored, then
// gives the result. Insert into an empty or full queue goes to the result;
// else each stored entry with a larger key is moved up by one RAM read and
// write. Reset clears count, head pointer and state, not the RAM.
// A stalled response waits in the output register while the next request
// is taken; the sequencer holds at its result step only if it is still full.
`default_nettype none

module sorted_event_priority_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sepq_in_if.sink    request,
    sepq_out_if.source response
);

    import sepq_pkg::*;

    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             mem_rdata;
    logic               res_valid;
    result_t            res;
    logic               out_free;
    logic               out_load;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;

    sepq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign mem_rdata = entry_t'(ram_rdata);

    sepq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free)
    );

    assign out_free = !out_valid_reg || response.ready;
    assign out_load = res_valid && out_free;

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res;
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.status          = out_data_reg.status;
    assign response.popped_key      = out_data_reg.popped.key;
    assign response.popped_travel   = out_data_reg.popped.travel;
    assign response.popped_ships    = out_data_reg.popped.ships;
    assign response.popped_attacker = out_data_reg.popped.attacker;
    assign response.popped_source   = out_data_reg.popped.source;
    assign response.popped_target   = out_data_reg.popped.target;
    assign response.count_after     = out_data_reg.count_after;
    assign response.head_valid      = out_data_reg.head_valid;
    assign response.head_key        = out_data_reg.head_key;

endmodule

`default_nettype wire

>>> bench/sorted_event_priority_queue_tb.sv
// ============================================================================
// sorted_event_priority_queue_tb: self-checking bench for the event queue
// Drives insert and pop words with random gaps, keeps a sorted shadow queue
// to predict every response word, and compares each response field by field.
// ============================================================================

module sorted_event_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sepq_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 100;
    localparam int IDLE_PCT        = 27;

    logic clk;
    logic rst_n;

    sepq_in_if  request ();
    sepq_out_if response ();

    sorted_event_priority_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    entry_t  shadow_events[$];
    result_t pending_results[$];
    result_t next_result;

    int error_count   = 0;
    int quiet_cycles  = 0;
    int rsp_hold_left = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Apply one accepted word to the shadow queue and queue its response.
    function automatic void update_shadow_queue(logic op, entry_t e);
        result_t r;
        int      pos;
        int      i;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_INSERT)
        begin
            if (shadow_events.size() >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = shadow_events.size();
                for (i = 0; i < shadow_events.size(); i++)
                begin
                    if (e.key < shadow_events[i].key)
                    begin
                        pos = i;
                        break;
                    end
                end
                shadow_events.insert(pos, e);
            end
        end
        else
        begin
            if (shadow_events.size() == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.popped = shadow_events.pop_front();
            end
        end
        r.count_after = COUNT_OUT_W'(shadow_events.size());
        if (shadow_events.size() > 0)
        begin
            r.head_valid = 1'b1;
            r.head_key   = shadow_events[0].key;
        end
        pending_results.push_back(r);
    endfunction

    function automatic entry_t random_entry(logic [KEY_W-1:0] key);
        entry_t e;
        e.key      = key;
        e.travel   = TRAVEL_W'($urandom());
        e.ships    = SHIPS_W'($urandom());
        e.attacker = ATK_W'($urandom());
        e.source   = PLANET_W'($urandom());
        e.target   = PLANET_W'($urandom());
        return e;
    endfunction

    // Bias toward small keys and keys near the maximum so that equal keys are common.
    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom_range(15));
            1: return {KEY_W{1'b1}} - KEY_W'($urandom_range(3));
            default: return KEY_W'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_word(logic op, entry_t e);
        while (sender_idles && $urandom_range(99) < IDLE_PCT)
        begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid          <= 1'b1;
        request.operation      <= op;
        request.arrival_key    <= e.key;
        request.travel_time    <= e.travel;
        request.ship_count     <= e.ships;
        request.attacker_index <= e.attacker;
        request.source_index   <= e.source;
        request.target_index   <= e.target;
        do
        begin
            @(posedge clk);
        end
        while (request.ready !== 1'b1);
        update_shadow_queue(op, e);
        @(negedge clk);
    endtask

    task automatic send_random_word(int insert_pct);
        logic op;
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
        send_word(op, random_entry(random_key()));
    endtask

    task automatic wait_for_drain();
        request.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Extremes of key and payload, equal keys, pop on empty.
    task automatic test_directed();
        entry_t e;
        send_word(OP_POP, random_entry(random_key()));
        e = '0;
        send_word(OP_INSERT, e);
        e = '1;
        send_word(OP_INSERT, e);
        send_word(OP_INSERT, random_entry(KEY_W'(24'h000100)));
        send_word(OP_INSERT, random_entry(KEY_W'(24'h000100)));
        send_word(OP_INSERT, random_entry(KEY_W'(24'h000100)));
        send_word(OP_INSERT, random_entry('0));
        repeat (7)
        begin
            send_word(OP_POP, random_entry(random_key()));
        end
        wait_for_drain();
    endtask

    // Fill past capacity, with responses held back at the start, then empty it.
    task automatic test_full_queue();
        rsp_hold_left = RSP_HOLD_CYCLES;
        repeat (DEPTH + 2)
        begin
            send_word(OP_INSERT, random_entry(random_key()));
        end
        send_word(OP_POP, random_entry(random_key()));
        send_word(OP_INSERT, random_entry(random_key()));
        repeat (DEPTH + 1)
        begin
            send_word(OP_POP, random_entry(random_key()));
        end
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (100)
        begin
            send_random_word(55);
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Alternate growth and shrink phases so the fill level wanders widely.
    task automatic test_random_mix();
        int n;
        for (n = 0; n < 250; n++)
        begin
            send_random_word(((n / 50) % 2 == 0) ? 75 : 25);
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        request.valid          = 1'b0;
        request.operation      = OP_INSERT;
        request.arrival_key    = '0;
        request.travel_time    = '0;
        request.ship_count     = '0;
        request.attacker_index = '0;
        request.source_index   = '0;
        request.target_index   = '0;
        repeat (2)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_queue();
        test_back_to_back();
        test_random_mix();

        request.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Response side: random back-pressure, or a counted hold-off when asked.
    initial
    begin
        response.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left > 0)
            begin
                response.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
            begin
                response.ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && response.valid === 1'b1 && response.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("response word with no request pending");
            end
            else
            begin
                next_result = pending_results.pop_front();
                check_field("status", 32'(response.status), 32'(next_result.status));
                check_field("popped_key", 32'(response.popped_key),
                            32'(next_result.popped.key));
                check_field("popped_travel", 32'(response.popped_travel),
                            32'(next_result.popped.travel));
                check_field("popped_ships", 32'(response.popped_ships),
                            32'(next_result.popped.ships));
                check_field("popped_attacker", 32'(response.popped_attacker),
                            32'(next_result.popped.attacker));
                check_field("popped_source", 32'(response.popped_source),
                            32'(next_result.popped.source));
                check_field("popped_target", 32'(response.popped_target),
                            32'(next_result.popped.target));
                check_field("count_after", 32'(response.count_after),
                            32'(next_result.count_after));
                check_field("head_valid", 32'(response.head_valid),
                            32'(next_result.head_valid));
                check_field("head_key", 32'(response.head_key),
                            32'(next_result.head_key));
            end
        end
    end

    // Abort if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (request.valid === 1'b1 && request.ready === 1'b1)
            || (response.valid === 1'b1 && response.ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

>>> sorted_event_priority_queue.f
design/sepq_pkg.sv
design/sepq_if.sv
design/sepq_ram.sv
design/sepq_seq.sv
design/sorted_event_priority_queue.sv
bench/sorted_event_priority_queue_tb.sv
